// ===== design/irlp_pkg.sv =====
// Shared constants, phase encoding and result type for the resolution line parser.
package irlp_pkg;

	localparam int unsigned ExtW = 31;
	localparam int unsigned AccW = ExtW + 4;

	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChX     = 8'h58;
	localparam logic [7:0] ChY     = 8'h59;
	localparam logic [7:0] ChSp    = 8'h20;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;

	typedef enum logic [3:0] {
		PH_SIGN1   = 4'd0,
		PH_AXIS1   = 4'd1,
		PH_GAP1    = 4'd2,
		PH_BLANKS1 = 4'd3,
		PH_DIG1    = 4'd4,
		PH_SIGN2   = 4'd5,
		PH_AXIS2   = 4'd6,
		PH_GAP2    = 4'd7,
		PH_BLANKS2 = 4'd8,
		PH_DIG2    = 4'd9,
		PH_TAIL    = 4'd10
	} phase_t;

	typedef struct packed {
		logic            line_ok;
		logic            y_first;
		logic            x_up;
		logic            y_up;
		logic [ExtW-1:0] image_width;
		logic [ExtW-1:0] image_height;
	} res_t;

endpackage

// ===== design/irlp_step.sv =====
// Parser state registers and the per-byte state update.
module irlp_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          char_byte,
	input  logic                line_end,
	output irlp_pkg::res_t      res
);

	irlp_pkg::phase_t                phase_q, ph_n;
	logic                            first_y_q, fy_n;
	logic                            first_plus_q, fp_n;
	logic                            second_plus_q, sp_n;
	logic [irlp_pkg::ExtW-1:0]       first_val_q, fv_n;
	logic [irlp_pkg::ExtW-1:0]       acc_q, acc_n;
	logic                            failed_q, fail_n;
	logic                            tail_q, tail_n;

	logic                            is_blank, is_digit, is_eol, is_sign, is_axis;
	logic [3:0]                      dig;
	logic [irlp_pkg::AccW-1:0]       acc_wide, prod;
	logic                            ok;

	assign is_blank = (char_byte == irlp_pkg::ChSp) || (char_byte == irlp_pkg::ChTab);
	assign is_eol   = (char_byte == irlp_pkg::ChCr) || (char_byte == irlp_pkg::ChLf);
	assign is_digit = (char_byte >= irlp_pkg::ChZero) && (char_byte <= irlp_pkg::ChNine);
	assign is_sign  = (char_byte == irlp_pkg::ChPlus) || (char_byte == irlp_pkg::ChMinus);
	assign is_axis  = (char_byte == irlp_pkg::ChX) || (char_byte == irlp_pkg::ChY);
	assign dig      = 4'(char_byte - irlp_pkg::ChZero);

	// acc*10 + digit, widened so overflow past the 31-bit extent shows in the top bits
	assign acc_wide = {4'b0, acc_q};
	assign prod     = (acc_wide << 3) + (acc_wide << 1) + {{(irlp_pkg::AccW-4){1'b0}}, dig};

	always_comb begin
		ph_n   = phase_q;
		fy_n   = first_y_q;
		fp_n   = first_plus_q;
		sp_n   = second_plus_q;
		fv_n   = first_val_q;
		acc_n  = acc_q;
		fail_n = failed_q;
		tail_n = tail_q;
		if (!failed_q) begin
			unique case (phase_q)
				irlp_pkg::PH_SIGN1: begin
					if (is_sign) begin
						fp_n = (char_byte == irlp_pkg::ChPlus);
						ph_n = irlp_pkg::PH_AXIS1;
					end else if (!is_blank) begin
						fail_n = 1'b1;
					end
				end
				irlp_pkg::PH_AXIS1: begin
					if (is_axis) begin
						fy_n = (char_byte == irlp_pkg::ChY);
						ph_n = irlp_pkg::PH_GAP1;
					end else begin
						fail_n = 1'b1;
					end
				end
				irlp_pkg::PH_AXIS2: begin
					if (is_axis && ((char_byte == irlp_pkg::ChY) != first_y_q)) begin
						ph_n = irlp_pkg::PH_GAP2;
					end else begin
						fail_n = 1'b1;
					end
				end
				irlp_pkg::PH_GAP1: begin
					if (is_blank) ph_n = irlp_pkg::PH_BLANKS1;
					else fail_n = 1'b1;
				end
				irlp_pkg::PH_GAP2: begin
					if (is_blank) ph_n = irlp_pkg::PH_BLANKS2;
					else fail_n = 1'b1;
				end
				irlp_pkg::PH_BLANKS1, irlp_pkg::PH_BLANKS2: begin
					if (is_digit) begin
						acc_n = {{(irlp_pkg::ExtW-4){1'b0}}, dig};
						ph_n  = (phase_q == irlp_pkg::PH_BLANKS1) ?
							irlp_pkg::PH_DIG1 : irlp_pkg::PH_DIG2;
					end else if (!is_blank) begin
						fail_n = 1'b1;
					end
				end
				irlp_pkg::PH_DIG1: begin
					if (is_digit) begin
						if (prod[irlp_pkg::AccW-1:irlp_pkg::ExtW] != '0) fail_n = 1'b1;
						else acc_n = prod[irlp_pkg::ExtW-1:0];
					end else if (acc_q == '0) begin
						fail_n = 1'b1;
					end else begin
						fv_n  = acc_q;
						acc_n = '0;
						if (is_sign) begin
							sp_n = (char_byte == irlp_pkg::ChPlus);
							ph_n = irlp_pkg::PH_AXIS2;
						end else if (is_blank) begin
							ph_n = irlp_pkg::PH_SIGN2;
						end else begin
							fail_n = 1'b1;
						end
					end
				end
				irlp_pkg::PH_SIGN2: begin
					if (is_sign) begin
						sp_n = (char_byte == irlp_pkg::ChPlus);
						ph_n = irlp_pkg::PH_AXIS2;
					end else if (!is_blank) begin
						fail_n = 1'b1;
					end
				end
				irlp_pkg::PH_DIG2: begin
					if (is_digit) begin
						if (prod[irlp_pkg::AccW-1:irlp_pkg::ExtW] != '0) fail_n = 1'b1;
						else acc_n = prod[irlp_pkg::ExtW-1:0];
					end else if ((acc_q == '0) || !(is_blank || is_eol)) begin
						fail_n = 1'b1;
					end else begin
						ph_n = irlp_pkg::PH_TAIL;
						if (is_eol) tail_n = 1'b1;
					end
				end
				irlp_pkg::PH_TAIL: begin
					if (is_eol) tail_n = 1'b1;
					else if (!(is_blank && !tail_q)) fail_n = 1'b1;
				end
				default: fail_n = 1'b1;
			endcase
		end
	end

	assign ok = !fail_n &&
		(((ph_n == irlp_pkg::PH_DIG2) && (acc_n != '0)) || (ph_n == irlp_pkg::PH_TAIL));

	always_comb begin
		res = '0;
		if (ok) begin
			res.line_ok = 1'b1;
			res.y_first = fy_n;
			if (!fy_n) begin
				res.x_up         = fp_n;
				res.y_up         = sp_n;
				res.image_width  = fv_n;
				res.image_height = acc_n;
			end else begin
				res.x_up         = sp_n;
				res.y_up         = fp_n;
				res.image_width  = acc_n;
				res.image_height = fv_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= irlp_pkg::PH_SIGN1;
			first_y_q     <= 1'b0;
			first_plus_q  <= 1'b0;
			second_plus_q <= 1'b0;
			first_val_q   <= '0;
			acc_q         <= '0;
			failed_q      <= 1'b0;
			tail_q        <= 1'b0;
		end else if (fire) begin
			if (line_end) begin
				// line done: start clean for the next one
				phase_q       <= irlp_pkg::PH_SIGN1;
				first_y_q     <= 1'b0;
				first_plus_q  <= 1'b0;
				second_plus_q <= 1'b0;
				first_val_q   <= '0;
				acc_q         <= '0;
				failed_q      <= 1'b0;
				tail_q        <= 1'b0;
			end else begin
				phase_q       <= ph_n;
				first_y_q     <= fy_n;
				first_plus_q  <= fp_n;
				second_plus_q <= sp_n;
				first_val_q   <= fv_n;
				acc_q         <= acc_n;
				failed_q      <= fail_n;
				tail_q        <= tail_n;
			end
		end
	end

endmodule

// ===== design/image_resolution_line_parser_top.sv =====
// Top level of the HDR resolution line parser: input register, parser, result register.
// Takes one character of a resolution line per cycle on a valid/ready request channel and,
// for the character flagged line_end, gives one result holding line_ok, the axis order,
// both axis directions and the width and height (all zero when the line is malformed).
// Throughput is one character per clock, set by the parser state update (a 31-bit
// multiply-by-ten accumulate and compare), but a line_end character waits in the input
// register until the result register is free. The result is presented from the output
// register the cycle after the last character is parsed; the next line flows in meanwhile.
module image_resolution_line_parser_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      char_byte,
	input  logic                            line_end,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            line_ok,
	output logic                            y_first,
	output logic                            x_up,
	output logic                            y_up,
	output logic [irlp_pkg::ExtW-1:0]       image_width,
	output logic [irlp_pkg::ExtW-1:0]       image_height
);

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            end_s1;
	logic            out_valid_q;
	irlp_pkg::res_t  res, res_q;
	logic            out_free, adv;

	assign out_free = !out_valid_q || out_ready;
	// a last character only moves on when the result register can take its result
	assign adv      = valid_s1 && (!end_s1 || out_free);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_byte;
			end_s1  <= line_end;
		end
	end

	irlp_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.char_byte (char_s1),
		.line_end  (end_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && end_s1) res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign line_ok      = res_q.line_ok;
	assign y_first      = res_q.y_first;
	assign x_up         = res_q.x_up;
	assign y_up         = res_q.y_up;
	assign image_width  = res_q.image_width;
	assign image_height = res_q.image_height;

endmodule
